// ===== src/tphl_pkg.sv =====
// Shared types, codes and helpers for the terrain plane height lookup.
package tphl_pkg;

   localparam int STRIP_DEPTH_DEF  = 256;
   localparam int TABLE_DEPTH_DEF  = 1024;
   localparam int NORMAL_DEPTH_DEF = 256;
   localparam int MAX_HITS_DEF     = 10;

   localparam logic [2:0] OP_QUERY  = 3'd0;
   localparam logic [2:0] OP_STRIP  = 3'd1;
   localparam logic [2:0] OP_ACCESS = 3'd2;
   localparam logic [2:0] OP_PLATE  = 3'd3;
   localparam logic [2:0] OP_POINT  = 3'd4;
   localparam logic [2:0] OP_NORMAL = 3'd5;
   localparam logic [2:0] OP_OFFSET = 3'd6;

   localparam logic CSR_MAP_LOADED  = 1'b0;
   localparam logic CSR_STRIP_COUNT = 1'b1;

   typedef struct packed {
      logic signed [31:0] bound;
      logic [9:0]         start;
      logic [10:0]        len;
   } strip_entry_type;

   typedef struct packed {
      logic [9:0] first;
      logic [9:0] second;
      logic [7:0] nrm;
      logic [7:0] off;
   } plate_entry_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] z;
   } point_entry_type;

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
   } normal_entry_type;

   typedef struct packed {
      logic mul_go;
      logic div_go;
   } arith_ctl_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
   } arith_sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [34:0] hi_lim;
      logic signed [34:0] lo_lim;
      hi_lim = 35'sh0_7FFF_FFFF;
      lo_lim = -35'sh0_8000_0000;
      if (v > hi_lim) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo_lim) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== src/tphl_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module tphl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== src/tphl_arith.sv =====
// Shared fixed point unit: registered 32x32 multiply and a bit-serial divider.
module tphl_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  tphl_pkg::arith_ctl_type ctl,
   input  logic signed [31:0]     mul_a,
   input  logic signed [31:0]     mul_b,
   input  logic signed [31:0]     div_n,
   input  logic signed [31:0]     div_d,
   output logic signed [31:0]     mul_res,
   output logic signed [31:0]     div_res,
   output tphl_pkg::arith_sts_type sts
);
   import tphl_pkg::*;

   localparam int QW = 44;

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_rnd;
   logic signed [63:0] prod_sh;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [31:0]   rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [QW-1:0] num_ff, num_in;
   logic [31:0]   den_ff, den_in;
   logic          neg_ff, neg_in;
   logic signed [31:0] res_ff, res_in;

   logic [32:0]   n_ext, d_ext, n_neg, d_neg;
   logic [31:0]   n_mag, d_mag;
   logic [32:0]   rem_sh;
   logic          ge;
   logic [32:0]   rem_sub;
   logic [QW-1:0] quo_nx;
   logic [QW-1:0] quo_neg;

   always_ff @(posedge clock) begin
      if (ctl.mul_go) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   always_comb begin
      prod_rnd = prod_ff + 64'sd2048;
      prod_sh  = prod_rnd >>> 12;
      if (prod_sh > 64'sh7FFF_FFFF) begin
         mul_res = 32'sh7FFF_FFFF;
      end else if (prod_sh < -64'sh8000_0000) begin
         mul_res = 32'sh8000_0000;
      end else begin
         mul_res = prod_sh[31:0];
      end
   end

   always_comb begin
      n_ext   = {div_n[31], div_n};
      d_ext   = {div_d[31], div_d};
      n_neg   = -n_ext;
      d_neg   = -d_ext;
      n_mag   = div_n[31] ? n_neg[31:0] : div_n;
      d_mag   = div_d[31] ? d_neg[31:0] : div_d;
      rem_sh  = {rem_ff, num_ff[QW-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      quo_nx  = {quo_ff[QW-2:0], ge};
      quo_neg = -quo_nx;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;

      if (ctl.div_go) begin
         if (div_d == '0) begin
            done_in = 1'b1;
            if (div_n > 0) begin
               res_in = 32'sh7FFF_FFFF;
            end else if (div_n < 0) begin
               res_in = 32'sh8000_0000;
            end else begin
               res_in = '0;
            end
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = '0;
            quo_in  = '0;
            num_in  = {n_mag, 12'd0};
            den_in  = d_mag;
            neg_in  = div_n[31] ^ div_d[31];
         end
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[31:0] : rem_sh[31:0];
         quo_in = quo_nx;
         num_in = {num_ff[QW-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               res_in = (quo_nx > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : quo_nx[31:0];
            end else begin
               res_in = (quo_nx > QW'(32'h8000_0000)) ? 32'sh8000_0000 : quo_neg[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      num_ff <= num_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign div_res      = res_ff;
   assign sts.div_busy = busy_ff;
   assign sts.div_done = done_ff;
endmodule

// ===== src/terrain_plane_height_lookup.sv =====
// Top level: table stores, query sequencer and result register.
//
//   channel | ports                | moves
//   --------+----------------------+---------------------------------------
//   req     | req_valid/req_ready  | one operation beat (write or query)
//   rsp     | rsp_valid/rsp_ready  | one result beat (found, height)
//   csr     | csr_wen              | map_loaded / strip_count write
//
// Writes and failed queries answer in the cycle after they are taken. A query
// runs a bisection over the strip bounds, reads the strip, then reads the access,
// plate and point entries of each plate in the strip's list, and for each hit
// adds two multiplies and a 44-step divide; it then finishes the result.
// Each table has a single read port, and the divider works one bit at a time.
// Reset clears the sequencer, result valid and CSR registers; tables are not cleared.
// A new beat is taken only when idle and the result register is free.
module terrain_plane_height_lookup #(
   parameter int STRIP_DEPTH  = tphl_pkg::STRIP_DEPTH_DEF,
   parameter int TABLE_DEPTH  = tphl_pkg::TABLE_DEPTH_DEF,
   parameter int NORMAL_DEPTH = tphl_pkg::NORMAL_DEPTH_DEF,
   parameter int MAX_HITS     = tphl_pkg::MAX_HITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic [9:0]         req_entry_index,
   input  logic signed [31:0] req_word_a,
   input  logic signed [31:0] req_word_b,
   input  logic signed [31:0] req_word_c,
   input  logic [9:0]         req_link_a,
   input  logic [10:0]        req_link_b,
   input  logic [7:0]         req_link_c,
   input  logic [7:0]         req_link_d,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic signed [31:0] rsp_height,
   input  logic               csr_wen,
   input  logic               csr_index,
   input  logic [8:0]         csr_wdata
);
   import tphl_pkg::*;

   localparam int SW = $clog2(STRIP_DEPTH);
   localparam int TW = $clog2(TABLE_DEPTH);
   localparam int NW = $clog2(NORMAL_DEPTH);
   localparam int HW = $clog2(MAX_HITS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_BIS_A, ST_BIS_B, ST_STR_A, ST_STR_B, ST_SCAN, ST_ACC, ST_PLATE,
      ST_PT1, ST_PT2, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_DIV, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic               map_loaded_ff;
   logic [8:0]         strip_count_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic signed [31:0] rsp_height_ff, rsp_height_in;

   logic signed [31:0] cur_ff, cur_in, x_ff, x_in, z_ff, z_in;
   logic [SW-1:0]      lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, sel_ff, sel_in;
   logic [9:0]         start_ff, start_in;
   logic [10:0]        len_ff, len_in, i_ff, i_in;
   logic [HW-1:0]      hits_ff, hits_in;
   logic [9:0]         second_ff, second_in;
   logic signed [31:0] pax_ff, pax_in, paz_ff, paz_in;
   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in, off_ff, off_in;
   logic signed [31:0] m1_ff, m1_in, best_ff, best_in;
   logic [32:0]        bestd_ff, bestd_in;

   logic               req_fire, slot_free;
   logic [31:0]        ent32, cnt32, n32, hi32, pos32, accp32, first32, second32;
   logic [31:0]        nrm32, off32, nsec32;
   logic [SW:0]        lo1, mid_lo, mid_hi;

   strip_entry_type    strip_rdata;
   logic [9:0]         acc_rdata;
   plate_entry_type    plate_rdata;
   point_entry_type    point_rdata;
   normal_entry_type   normal_rdata;
   logic signed [31:0] offset_rdata;

   logic               strip_we, acc_we, plate_we, point_we, normal_we, offset_we;
   logic [SW-1:0]      strip_raddr;
   logic [TW-1:0]      point_raddr;

   arith_ctl_type      actl;
   arith_sts_type      asts;
   logic signed [31:0] mul_a, mul_b, div_n, mul_res, div_res;
   logic signed [34:0] sum35;
   logic signed [31:0] sum32, neg32;
   logic signed [32:0] diff;
   logic [32:0]        absd;
   logic signed [31:0] rx0, rx1, rz0, rz1;
   logic               in_rect;

   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) & slot_free;
   assign req_fire  = req_valid & req_ready;
   assign ent32     = 32'(req_entry_index);

   assign strip_we  = req_fire && req_operation == OP_STRIP  && ent32 < STRIP_DEPTH;
   assign acc_we    = req_fire && req_operation == OP_ACCESS && ent32 < TABLE_DEPTH;
   assign plate_we  = req_fire && req_operation == OP_PLATE  && ent32 < TABLE_DEPTH;
   assign point_we  = req_fire && req_operation == OP_POINT  && ent32 < TABLE_DEPTH;
   assign normal_we = req_fire && req_operation == OP_NORMAL && ent32 < NORMAL_DEPTH;
   assign offset_we = req_fire && req_operation == OP_OFFSET && ent32 < NORMAL_DEPTH;

   assign pos32    = 32'(start_ff) + 32'(i_ff);
   assign accp32   = 32'(acc_rdata);
   assign first32  = 32'(plate_rdata.first);
   assign second32 = 32'(plate_rdata.second);
   assign nrm32    = 32'(plate_rdata.nrm);
   assign off32    = 32'(plate_rdata.off);
   assign nsec32   = 32'(second_ff);

   assign strip_raddr = (state_ff == ST_BIS_A) ? mid_ff : sel_ff;
   assign point_raddr = (state_ff == ST_PLATE) ? first32[TW-1:0] : nsec32[TW-1:0];

   tphl_ram #(.WIDTH($bits(strip_entry_type)), .DEPTH(STRIP_DEPTH)) u_strip (
      .clock(clock), .we(strip_we), .waddr(ent32[SW-1:0]),
      .wdata({req_word_a, req_link_a, req_link_b}),
      .raddr(strip_raddr), .rdata(strip_rdata)
   );

   tphl_ram #(.WIDTH(10), .DEPTH(TABLE_DEPTH)) u_access (
      .clock(clock), .we(acc_we), .waddr(ent32[TW-1:0]), .wdata(req_link_a),
      .raddr(pos32[TW-1:0]), .rdata(acc_rdata)
   );

   tphl_ram #(.WIDTH($bits(plate_entry_type)), .DEPTH(TABLE_DEPTH)) u_plate (
      .clock(clock), .we(plate_we), .waddr(ent32[TW-1:0]),
      .wdata({req_link_a, req_link_b[9:0], req_link_c, req_link_d}),
      .raddr(accp32[TW-1:0]), .rdata(plate_rdata)
   );

   tphl_ram #(.WIDTH($bits(point_entry_type)), .DEPTH(TABLE_DEPTH)) u_point (
      .clock(clock), .we(point_we), .waddr(ent32[TW-1:0]),
      .wdata({req_word_a, req_word_b}),
      .raddr(point_raddr), .rdata(point_rdata)
   );

   tphl_ram #(.WIDTH($bits(normal_entry_type)), .DEPTH(NORMAL_DEPTH)) u_normal (
      .clock(clock), .we(normal_we), .waddr(ent32[NW-1:0]),
      .wdata({req_word_a, req_word_b, req_word_c}),
      .raddr(nrm32[NW-1:0]), .rdata(normal_rdata)
   );

   tphl_ram #(.WIDTH(32), .DEPTH(NORMAL_DEPTH)) u_offset (
      .clock(clock), .we(offset_we), .waddr(ent32[NW-1:0]), .wdata(req_word_a),
      .raddr(off32[NW-1:0]), .rdata(offset_rdata)
   );

   tphl_arith u_arith (
      .clock(clock), .reset(reset), .ctl(actl),
      .mul_a(mul_a), .mul_b(mul_b), .div_n(div_n), .div_d(ny_ff),
      .mul_res(mul_res), .div_res(div_res), .sts(asts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         map_loaded_ff  <= 1'b0;
         strip_count_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_MAP_LOADED:  map_loaded_ff  <= csr_wdata[0];
            CSR_STRIP_COUNT: strip_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt32  = 32'(strip_count_ff);
      n32    = (cnt32 > STRIP_DEPTH) ? 32'(STRIP_DEPTH) : cnt32;
      hi32   = n32 - 32'd1;
      lo1    = {1'b0, lo_ff} + 1'b1;
      mid_lo = ({1'b0, lo_ff} + {1'b0, mid_ff}) >> 1;
      mid_hi = ({1'b0, mid_ff} + {1'b0, hi_ff}) >> 1;

      rx0 = (pax_ff <= point_rdata.x) ? pax_ff : point_rdata.x;
      rx1 = (pax_ff <= point_rdata.x) ? point_rdata.x : pax_ff;
      rz0 = (paz_ff <= point_rdata.z) ? paz_ff : point_rdata.z;
      rz1 = (paz_ff <= point_rdata.z) ? point_rdata.z : paz_ff;
      in_rect = rx0 <= x_ff && x_ff <= rx1 && rz0 <= z_ff && z_ff <= rz1;

      sum35 = 35'(m1_ff) + 35'(mul_res) + 35'(off_ff);
      sum32 = sat32(sum35);
      neg32 = sat32(-35'(sum32));
      diff  = 33'(cur_ff) - 33'(div_res);
      absd  = diff[32] ? -diff : diff;

      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_height_in = rsp_height_ff;
      cur_in = cur_ff; x_in = x_ff; z_in = z_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff; sel_in = sel_ff;
      start_in = start_ff; len_in = len_ff; i_in = i_ff; hits_in = hits_ff;
      second_in = second_ff; pax_in = pax_ff; paz_in = paz_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff; off_in = off_ff;
      m1_in = m1_ff; best_in = best_ff; bestd_in = bestd_ff;
      actl  = '0;
      mul_a = nx_ff;
      mul_b = x_ff;
      div_n = neg32;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_operation == OP_QUERY && map_loaded_ff && n32 != '0) begin
                  cur_in = req_word_a;
                  x_in   = req_word_b;
                  z_in   = req_word_c;
                  if (n32 == 32'd1) begin
                     sel_in   = '0;
                     state_in = ST_STR_A;
                  end else begin
                     lo_in    = '0;
                     hi_in    = hi32[SW-1:0];
                     mid_in   = hi32[SW:1];
                     state_in = ST_BIS_A;
                  end
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_found_in  = 1'b0;
                  rsp_height_in = '0;
               end
            end
         end
         ST_BIS_A: state_in = ST_BIS_B;
         ST_BIS_B: begin
            state_in = ST_BIS_A;
            if (strip_rdata.bound > z_ff) begin
               if ({1'b0, hi_ff} > lo1) begin
                  hi_in  = mid_ff;
                  mid_in = mid_lo[SW-1:0];
               end else begin
                  sel_in   = mid_ff;
                  state_in = ST_STR_A;
               end
            end else begin
               if (lo1 < {1'b0, hi_ff}) begin
                  lo_in  = mid_ff;
                  mid_in = mid_hi[SW-1:0];
               end else begin
                  sel_in   = mid_ff + 1'b1;
                  state_in = ST_STR_A;
               end
            end
         end
         ST_STR_A: state_in = ST_STR_B;
         ST_STR_B: begin
            start_in = strip_rdata.start;
            len_in   = strip_rdata.len;
            i_in     = '0;
            hits_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (i_ff < len_ff && 32'(hits_ff) < MAX_HITS && pos32 < TABLE_DEPTH) begin
               state_in = ST_ACC;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ACC: begin
            if (accp32 < TABLE_DEPTH) begin
               state_in = ST_PLATE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_PLATE: begin
            second_in = plate_rdata.second;
            if (first32 < TABLE_DEPTH && second32 < TABLE_DEPTH &&
                nrm32 < NORMAL_DEPTH && off32 < NORMAL_DEPTH) begin
               state_in = ST_PT1;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_PT1: begin
            pax_in   = point_rdata.x;
            paz_in   = point_rdata.z;
            nx_in    = normal_rdata.nx;
            ny_in    = normal_rdata.ny;
            nz_in    = normal_rdata.nz;
            off_in   = offset_rdata;
            state_in = ST_PT2;
         end
         ST_PT2: begin
            if (in_rect) begin
               state_in = ST_MUL_A;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_MUL_A: begin
            actl.mul_go = 1'b1;
            state_in    = ST_MUL_B;
         end
         ST_MUL_B: begin
            m1_in       = mul_res;
            mul_a       = nz_ff;
            mul_b       = z_ff;
            actl.mul_go = 1'b1;
            state_in    = ST_MUL_C;
         end
         ST_MUL_C: begin
            actl.div_go = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            if (asts.div_done) begin
               if (hits_ff == '0 || bestd_ff > absd) begin
                  best_in  = div_res;
                  bestd_in = absd;
               end
               hits_in  = hits_ff + 1'b1;
               i_in     = i_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = hits_ff != '0;
               rsp_height_in = (hits_ff != '0) ? best_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff  <= rsp_found_in;
      rsp_height_ff <= rsp_height_in;
      cur_ff <= cur_in; x_ff <= x_in; z_ff <= z_in;
      lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in; sel_ff <= sel_in;
      start_ff <= start_in; len_ff <= len_in; i_ff <= i_in; hits_ff <= hits_in;
      second_ff <= second_in; pax_ff <= pax_in; paz_ff <= paz_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in; off_ff <= off_in;
      m1_ff <= m1_in; best_ff <= best_in; bestd_ff <= bestd_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_height = rsp_height_ff;
endmodule
